[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent assertion that also holds through reset.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[design/btch_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btch_pkg: shared types and constants
// Defaults, arctangent table and pipeline control struct of the clock-hour
// bearing pipeline.
// ----------------------------------------------------------------------------
package btch_pkg;

  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_COORD_WIDTH  = 32;
  localparam int DEF_ANGLE_WIDTH  = 16;

  // angle accumulator width: 2^32 is one full turn
  localparam int ZW       = 32;
  localparam int ATAN_LEN = 24;
  localparam int HOURS    = 12;

  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ZW-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // per-stage control: request present, and offset was exactly zero
  typedef struct packed {
    logic valid;
    logic origin;
  } ctl_t;

endpackage

[design/btch_cordic_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btch_cordic_stage: one CORDIC vectoring iteration
// Rotates (x, y) toward the x axis by atan(2^-STEP) and registers the result.
// ----------------------------------------------------------------------------
module btch_cordic_stage import btch_pkg::*; #(
  parameter int STEP = 0,
  parameter int XW   = DEF_COORD_WIDTH + 2,
  parameter int AW   = DEF_ANGLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 in_ctl,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic [ZW-1:0]        z_in,
  input  logic [AW-1:0]        hd_in,
  input  logic                 down_ready,
  output logic                 up_ready,
  output ctl_t                 out_ctl,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic [ZW-1:0]        z_out,
  output logic [AW-1:0]        hd_out
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic [ZW-1:0]        z_next;

  assign up_ready = !out_ctl.valid || down_ready;

  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN_TURNS[STEP];
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN_TURNS[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (up_ready) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_ctl.valid) begin
      x_out  <= x_next;
      y_out  <= y_next;
      z_out  <= z_next;
      hd_out <= hd_in;
    end
  end

endmodule

[design/bearing_to_clock_hour.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bearing_to_clock_hour: clock-face hour of a target relative to a heading
// Pipelined CORDIC atan2 followed by heading subtraction and 1/12-turn
// rounding.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and returns the hour
// (1..12, 12 = straight ahead, clockwise) through one input register, one
// register per CORDIC iteration, one register for the heading subtraction
// and one for the hour. Every stage holds its own valid bit and advances
// whenever the stage after it is empty or moving, so bubbles close up and
// in_stall rises only once every stage is holding a request.
// A zero offset (both coordinates zero) reports the bearing as straight along
// the world x axis.
module bearing_to_clock_hour import btch_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
  parameter int ANGLE_WIDTH  = DEF_ANGLE_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] heading,
  input  logic signed [31:0] delta_x,
  input  logic signed [31:0] delta_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         clock_hour
);

  // two guard bits cover negation of the most negative value and CORDIC gain
  localparam int XW = COORD_WIDTH + 2;
  localparam int AW = ANGLE_WIDTH;
  localparam int N  = CORDIC_STEPS;
  localparam int PW = AW + 4;

  logic [COORD_WIDTH-1:0] raw_x;
  logic [COORD_WIDTH-1:0] raw_y;
  logic [AW-1:0]          raw_hd;
  logic signed [XW-1:0]   ext_x;
  logic signed [XW-1:0]   ext_y;

  // input stage registers
  ctl_t                 s0_ctl;
  logic signed [XW-1:0] s0_x;
  logic signed [XW-1:0] s0_y;
  logic [ZW-1:0]        s0_z;
  logic [AW-1:0]        s0_hd;

  // CORDIC pipeline taps: index k is the input of iteration k
  ctl_t                 cctl [0:N];
  logic signed [XW-1:0] cx   [0:N];
  logic signed [XW-1:0] cy   [0:N];
  logic [ZW-1:0]        cz   [0:N];
  logic [AW-1:0]        chd  [0:N];
  logic                 rdy  [0:N];

  logic          s0_ready;
  logic          f1_valid;
  logic          f1_ready;
  logic [AW-1:0] f1_clock;
  logic          f2_ready;

  logic [ZW-1:0] zr;
  logic [AW-1:0] world;
  logic [PW-1:0] prod;
  logic [3:0]    hour_raw;

  // Low COORD_WIDTH bits as two's complement; a wider width zero-extends.
  generate
    if (COORD_WIDTH <= 32) begin : g_narrow
      assign raw_x = delta_x[COORD_WIDTH-1:0];
      assign raw_y = delta_y[COORD_WIDTH-1:0];
    end else begin : g_wide
      assign raw_x = {{(COORD_WIDTH-32){1'b0}}, delta_x};
      assign raw_y = {{(COORD_WIDTH-32){1'b0}}, delta_y};
    end
    if (AW <= 16) begin : g_hd_narrow
      assign raw_hd = heading[AW-1:0];
    end else begin : g_hd_wide
      assign raw_hd = {{(AW-16){1'b0}}, heading};
    end
  endgenerate

  assign ext_x = {{2{raw_x[COORD_WIDTH-1]}}, raw_x};
  assign ext_y = {{2{raw_y[COORD_WIDTH-1]}}, raw_y};

  // Input stage: flag the zero offset and fold targets behind the observer
  // into the right half plane by a half-turn rotation.
  assign s0_ready = !s0_ctl.valid || rdy[0];
  assign in_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ctl <= '0;
    end else if (s0_ready) begin
      s0_ctl.valid  <= in_valid;
      s0_ctl.origin <= (raw_x == '0) && (raw_y == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_hd <= raw_hd;
      if (ext_x[XW-1]) begin
        s0_x <= -ext_x;
        s0_y <= -ext_y;
        s0_z <= HALF_TURN;
      end else begin
        s0_x <= ext_x;
        s0_y <= ext_y;
        s0_z <= '0;
      end
    end
  end

  assign cctl[0] = s0_ctl;
  assign cx[0]   = s0_x;
  assign cy[0]   = s0_y;
  assign cz[0]   = s0_z;
  assign chd[0]  = s0_hd;

  // One register stage per CORDIC iteration.
  generate
    for (genvar k = 0; k < N; k++) begin : g_step
      btch_cordic_stage #(
        .STEP (k),
        .XW   (XW),
        .AW   (AW)
      ) u_stage (
        .clk        (clk),
        .rst        (rst),
        .in_ctl     (cctl[k]),
        .x_in       (cx[k]),
        .y_in       (cy[k]),
        .z_in       (cz[k]),
        .hd_in      (chd[k]),
        .down_ready (rdy[k+1]),
        .up_ready   (rdy[k]),
        .out_ctl    (cctl[k+1]),
        .x_out      (cx[k+1]),
        .y_out      (cy[k+1]),
        .z_out      (cz[k+1]),
        .hd_out     (chd[k+1])
      );
    end
  endgenerate

  assign rdy[N] = f1_ready;

  // Round the bearing to AW bits (ties up), force zero for a zero offset,
  // and take heading minus bearing so the angle runs clockwise.
  always_comb begin
    zr    = cz[N] + (ZW'(1) << (ZW - 1 - AW));
    world = cctl[N].origin ? '0 : zr[ZW-1 -: AW];
  end

  assign f1_ready = !f1_valid || f2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_ready) begin
      f1_valid <= cctl[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_ready && cctl[N].valid) begin
      f1_clock <= chd[N] - world;
    end
  end

  // Hour = floor((clock * 12 + half turn) / turn); 0 and 12 both mean
  // straight ahead.
  always_comb begin
    prod     = {1'b0, f1_clock, 3'b000} + {2'b00, f1_clock, 2'b00}
             + (PW'(1) << (AW - 1));
    hour_raw = prod[PW-1 -: 4];
  end

  assign f2_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (f2_ready) begin
      out_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_ready && f1_valid) begin
      if (hour_raw == '0 || hour_raw == 4'(HOURS)) begin
        clock_hour <= 4'(HOURS);
      end else begin
        clock_hour <= hour_raw;
      end
    end
  end

endmodule

[design/btch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btch_checker: port-level checks of the clock-hour pipeline
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btch_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [15:0] heading,
  input logic signed [31:0] delta_x,
  input logic signed [31:0] delta_y,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         clock_hour
);

  logic [79:0] in_req;

  assign in_req = {heading, delta_x, delta_y};

  // every reported hour is on the clock face
  `ASSERT_CLK_RST(a_hour_range, clk, rst, out_valid |-> (clock_hour >= 4'd1 && clock_hour <= 4'd12))

  // reset empties the pipeline
  `ASSERT_CLK(a_reset_empty, clk, $past(rst) |-> !out_valid)

  // with the output side moving, every stage moves, so input is never held
  `ASSERT_CLK_RST(a_no_stall_when_draining, clk, rst, !out_stall |-> !in_stall)

  // a held request keeps its hour
  `ASSERT_CLK_RST(a_hold_hour, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(clock_hour)))

  // a stalled input request stays offered and unchanged
  `ASSERT_CLK_RST(a_in_hold, clk, rst, (in_valid && in_stall) |=> (in_valid && $stable(in_req)))

endmodule

bind bearing_to_clock_hour btch_checker u_checker (.*);

[dv/tb_bearing_to_clock_hour.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bearing_to_clock_hour: self-checking bench for the clock-hour quantizer
// Drives heading and target offsets through the valid/stall handshake,
// predicts each hour with a bit-exact CORDIC atan2 model and checks the
// results in order. Runs directed corner cases, then random traffic with
// and without idling on both sides, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_bearing_to_clock_hour;

  // input register + one per CORDIC step + heading subtract + hour register
  localparam int CORDIC_ITERS   = 16;
  localparam int PIPE_LATENCY   = CORDIC_ITERS + 3;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT    = 60000;

  localparam logic [31:0] HALF_TURN_Z = 32'h8000_0000;
  // half an LSB of the 16-bit output angle, in 2^-32 turn units
  localparam logic [31:0] ANGLE_ROUND = 32'h0000_8000;
  // odd multiples of this heading put a zero-bearing target on an hour boundary
  localparam int          TIE_STEP    = 8192;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_Z [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct {
    logic signed [15:0] heading;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } bearing_req_t;

  typedef struct {
    bearing_req_t req;
    logic [3:0]   hour;
  } hour_expect_t;

  logic               clk;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic signed [15:0] heading    = '0;
  logic signed [31:0] delta_x    = '0;
  logic signed [31:0] delta_y    = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [3:0]         clock_hour;

  bearing_req_t pending_reqs[$];
  hour_expect_t expected_hours[$];

  logic in_fire       = 1'b0;   // request taken at the last rising edge
  logic idle_on       = 1'b1;   // random idling on both sides
  logic rx_block_req  = 1'b0;   // ask the receiver for a long hold-off
  int   hold_count    = 0;
  int   cycle_count   = 0;
  int   err_count     = 0;

  bearing_to_clock_hour dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .heading    (heading),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .clock_hour (clock_hour)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predict the hour: CORDIC vectoring on 64-bit coordinates with a 32-bit
  // turn accumulator, round to 16 bits, subtract from the heading (this
  // negates the bearing so it runs clockwise), round to the nearest 1/12 turn.
  function automatic logic [3:0] clock_hour_of(logic signed [15:0] hdg,
                                               logic signed [31:0] dx,
                                               logic signed [31:0] dy);
    longint      px;
    longint      py;
    longint      sx;
    longint      sy;
    logic [31:0] turns;
    logic [31:0] rounded;
    logic [15:0] world;
    logic [15:0] rel;
    int          hr;
    px    = dx;
    py    = dy;
    turns = '0;
    // zero offset keeps the bearing at zero
    if (px != 0 || py != 0) begin
      // target behind: rotate by half a turn into the convergence range
      if (px < 0) begin
        px    = -px;
        py    = -py;
        turns = HALF_TURN_Z;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        sx = px >>> i;
        sy = py >>> i;
        if (py >= 0) begin
          px    = px + sy;
          py    = py - sx;
          turns = turns + ATAN_Z[i];
        end else begin
          px    = px - sy;
          py    = py + sx;
          turns = turns - ATAN_Z[i];
        end
      end
    end
    rounded = turns + ANGLE_ROUND;
    world   = rounded[31:16];
    rel     = hdg - world;
    // ties at exactly half an hour go up
    hr      = ((int'(rel) * 12 + 32768) >>> 16) % 12;
    if (hr == 0) hr = 12;
    return 4'(hr);
  endfunction

  task automatic report_mismatch(string what, bearing_req_t req,
                                 logic [3:0] want, logic [3:0] got);
    err_count++;
    $display("%0t MISMATCH %s: heading=%0d dx=%h dy=%h want=%0d got=%0d",
             $time, what, req.heading, req.dx, req.dy, want, got);
  endtask

  task automatic queue_req(logic [15:0] h, logic [31:0] x, logic [31:0] y);
    bearing_req_t r;
    r.heading = h;
    r.dx      = x;
    r.dy      = y;
    pending_reqs.push_back(r);
  endtask

  // Mostly full-range offsets, plus small, axis, zero, diagonal and extreme
  // offsets so that the sign and zero handling get plenty of traffic.
  task automatic queue_random(int count);
    logic [15:0] h;
    logic [31:0] x;
    logic [31:0] y;
    repeat (count) begin
      h = 16'($urandom);
      x = $urandom;
      y = $urandom;
      case ($urandom_range(9))
        5: begin
          x = $urandom_range(31) - 16;
          y = $urandom_range(31) - 16;
        end
        6: begin
          if ($urandom_range(1)) x = '0;
          else y = '0;
        end
        7: begin
          x = '0;
          y = '0;
          if ($urandom_range(1)) h = 16'(TIE_STEP * (2 * $urandom_range(3) + 1));
        end
        8: begin
          y = $urandom_range(1) ? x : -x;
        end
        9: begin
          case ($urandom_range(4))
            0: x = 32'h8000_0000;
            1: x = 32'h7FFF_FFFF;
            2: x = 32'h0000_0000;
            3: x = 32'hFFFF_FFFF;
            default: x = 32'h0000_0001;
          endcase
          case ($urandom_range(4))
            0: y = 32'h8000_0000;
            1: y = 32'h7FFF_FFFF;
            2: y = 32'h0000_0000;
            3: y = 32'hFFFF_FFFF;
            default: y = 32'h0000_0001;
          endcase
        end
        default: ;
      endcase
      queue_req(h, x, y);
    end
  endtask

  // Hold the sender until every queued request is taken and answered.
  task automatic wait_all_returned();
    while (pending_reqs.size() != 0 || in_valid || expected_hours.size() != 0)
      @(posedge clk);
  endtask

  // Sender: advance to the next request once the current one is taken,
  // otherwise hold the payload steady. Idle now and then when allowed.
  always @(negedge clk) begin : drive_requests
    bearing_req_t r;
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_reqs.size() != 0 && !(idle_on && $urandom_range(99) < 7)) begin
        r        = pending_reqs.pop_front();
        heading  <= r.heading;
        delta_x  <= r.dx;
        delta_y  <= r.dy;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: serve a long hold-off when asked, else stall at random.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_block_req && hold_count < RX_HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 7);
    end
  end

  // Check results against the oldest expectation first, then record the
  // request taken at this edge; one process keeps the queue order fixed.
  always @(posedge clk) begin : check_results
    hour_expect_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_hours.size() == 0) begin
          e.req = '{default: '0};
          report_mismatch("result with no request outstanding", e.req, 4'd0,
                          clock_hour);
        end else begin
          e = expected_hours.pop_front();
          if (clock_hour !== e.hour)
            report_mismatch("clock_hour", e.req, e.hour, clock_hour);
        end
      end
      if (in_valid && !in_stall) begin
        e.req.heading = heading;
        e.req.dx      = delta_x;
        e.req.dy      = delta_y;
        e.hour        = clock_hour_of(heading, delta_x, delta_y);
        expected_hours.push_back(e);
      end
    end
    in_fire <= !rst && in_valid && !in_stall;
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero offset, ties at half an hour, coordinate extremes,
    // targets behind and on the axes, heading extremes
    queue_req(16'sd0,      32'h0,          32'h0);
    queue_req(16'h7FFF,    32'h0,          32'h0);
    queue_req(16'h8000,    32'h0,          32'h0);
    queue_req(16'(TIE_STEP),     32'h0,    32'h0);
    queue_req(16'(3 * TIE_STEP), 32'h0,    32'h0);
    queue_req(16'(-TIE_STEP),    32'h0,    32'h0);
    queue_req(16'(TIE_STEP - 1), 32'h0,    32'h0);
    queue_req(16'(TIE_STEP + 1), 32'h0,    32'h0);
    queue_req(16'h0,       32'h7FFF_FFFF,  32'h0);
    queue_req(16'h0,       32'h8000_0000,  32'h0);
    queue_req(16'h0,       32'h0,          32'h7FFF_FFFF);
    queue_req(16'h0,       32'h0,          32'h8000_0000);
    queue_req(16'h0,       32'h8000_0000,  32'h8000_0000);
    queue_req(16'h0,       32'h7FFF_FFFF,  32'h7FFF_FFFF);
    queue_req(16'h0,       32'h7FFF_FFFF,  32'h8000_0000);
    queue_req(16'h0,       32'h8000_0000,  32'h7FFF_FFFF);
    queue_req(16'h0,       32'hFFFF_FFFF,  32'h0);
    queue_req(16'h0,       32'hFFFF_FFFF,  32'h1);
    queue_req(16'h0,       32'hFFFF_FFFF,  32'hFFFF_FFFF);
    queue_req(16'h0,       32'h1,          32'h0);
    queue_req(16'h0,       32'h0,          32'h1);
    queue_req(16'h0,       32'h0,          32'hFFFF_FFFF);
    queue_req(16'h4000,    32'h1,          32'h1);
    queue_req(16'h8000,    32'hFFFF_FFFB,  32'h3);

    queue_random(300);

    // hold the output long enough for the pipeline to fill and stall its
    // input while the sender keeps offering
    queue_random(80);
    rx_block_req = 1'b1;
    while (hold_count < RX_HOLD_CYCLES) @(posedge clk);
    rx_block_req = 1'b0;

    // pause the sender until every result is back
    wait_all_returned();

    // back-to-back traffic with no idling on either side
    idle_on = 1'b0;
    queue_random(250);
    wait_all_returned();

    idle_on = 1'b1;
    queue_random(200);
    wait_all_returned();

    // let any stray result surface
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[bearing_to_clock_hour.f]
+incdir+design
design/btch_pkg.sv
design/btch_cordic_stage.sv
design/bearing_to_clock_hour.sv
design/btch_checker.sv
dv/tb_bearing_to_clock_hour.sv
